FILE: hdl/knn_pkg.sv
// Shared constants, codes and types for the nearest-neighbor classifier.
// Used by knn_front, knn_back and the top level knn_nearest_class_vote.
package knn_pkg;

  localparam int FEATURES = 40;
  localparam int K_MAX    = 5;
  localparam int CLASSES  = 10;

  localparam int CMD_W      = 2;
  localparam int IDX_W      = 6;
  localparam int VAL_W      = 7;
  localparam int CLS_W      = 4;
  localparam int DIST_W     = 19;
  localparam int RANK_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam int QA_W   = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int KI_W   = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int KC_W   = $clog2(K_MAX + 1);
  localparam int CI_W   = $clog2(CLASSES);
  localparam int SQ_W   = 2 * VAL_W;

  localparam int QDEPTH = 4;
  localparam int QP_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic KIND_NEIGHBOR = 1'b0;
  localparam logic KIND_CLASS    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_METRIC_SELECT  = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    OP_QUERY    = 2'd0,
    OP_TRAIN    = 2'd1,
    OP_CLASSIFY = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             idx_ok;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
    logic [CLS_W-1:0] cls;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [KC_W-1:0] k;
    logic            metric;
  } cfg_t;

  typedef struct packed {
    logic [KC_W-1:0] list_fill;
    logic            classify_busy;
  } stat_t;

endpackage

FILE: hdl/knn_front.sv
// Front end: takes input transactions, decodes them into items and queues them.
// Depends on knn_pkg for item_t and the queue depth.
module knn_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [knn_pkg::CMD_W-1:0] in_cmd,
  input  logic [knn_pkg::IDX_W-1:0] in_feature_index,
  input  logic [knn_pkg::VAL_W-1:0] in_feature_value,
  input  logic [knn_pkg::CLS_W-1:0] in_sample_class,
  input  logic                      in_last_feature,
  output logic                      q_valid,
  output knn_pkg::item_t            q_item,
  input  logic                      q_pop
);
  import knn_pkg::*;

  item_t            queue_r [QDEPTH];
  logic [QP_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]  count_r, count_nxt;
  item_t            item_in;
  logic             push, pop;

  assign in_stall = (count_r == QC_W'(QDEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = queue_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  // Range-check the index and clamp the class once, here.
  always_comb begin
    item_in.op     = op_t'(in_cmd);
    item_in.idx_ok = (32'(in_feature_index) < FEATURES);
    item_in.idx    = in_feature_index;
    item_in.value  = in_feature_value;
    item_in.cls    = (32'(in_sample_class) > CLASSES - 1) ? CLS_W'(CLASSES - 1)
                                                          : in_sample_class;
    item_in.last   = in_last_feature;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QDEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QDEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + QC_W'(push) - QC_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: hdl/knn_back.sv
// Back end: query memory, distance pipeline, sorted neighbor list and vote sequencer.
// Depends on knn_pkg; fed from the knn_front queue, drives the result register.
module knn_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  knn_pkg::item_t              q_item,
  output logic                        q_pop,
  input  knn_pkg::cfg_t               cfg,
  output knn_pkg::stat_t              stat,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_result_kind,
  output logic [knn_pkg::RANK_W-1:0]  out_rank,
  output logic [knn_pkg::DIST_W-1:0]  out_distance,
  output logic [knn_pkg::CLS_W-1:0]   out_class_label,
  output logic                        out_last
);
  import knn_pkg::*;

  // Query memory, read data registered
  logic [VAL_W-1:0]  qmem [FEATURES];
  logic [VAL_W-1:0]  q_rd_r;
  logic [QA_W-1:0]   q_addr;

  // Stage B: difference and square
  logic              b_valid_r;
  item_t             b_item_r;
  logic [VAL_W-1:0]  diff;
  logic [SQ_W-1:0]   sq, term;

  // Stage C: accumulate
  logic              c_valid_r;
  op_t               c_op_r;
  logic [SQ_W-1:0]   c_term_r;
  logic              c_last_r;
  logic [CLS_W-1:0]  c_cls_r;
  logic [DIST_W-1:0] sum_r, sum_nxt;
  logic [DIST_W:0]   sum_ext;
  logic [DIST_W-1:0] sum_sat;
  logic              d_valid_nxt;

  // Stage D: list update and classify
  logic              d_valid_r;
  op_t               d_op_r;
  logic [DIST_W-1:0] d_dist_r;
  logic [CLS_W-1:0]  d_cls_r;
  logic [DIST_W-1:0] best_d_r [K_MAX];
  logic [CLS_W-1:0]  best_c_r [K_MAX];
  logic [DIST_W-1:0] new_d [K_MAX];
  logic [CLS_W-1:0]  new_c [K_MAX];
  logic [K_MAX-1:0]  keep;
  logic [KC_W-1:0]   fill_r, fill_nxt, n_held, fill_ins;
  logic              adv, d_done;

  // Vote sequencer
  logic [KC_W-1:0]   seq_r;
  logic [KI_W-1:0]   seq_idx;
  logic [KC_W-1:0]   votes_r [CLASSES];
  logic [KC_W-1:0]   vote_inc;
  logic [CLS_W-1:0]  vote_cls;
  logic [CLS_W-1:0]  win_cls_r;
  logic [KC_W-1:0]   win_cnt_r;
  logic              is_classify, load_ok, emit_entry, emit_final;

  // Result register
  logic              out_valid_r;
  logic              out_kind_r;
  logic [RANK_W-1:0] out_rank_r;
  logic [DIST_W-1:0] out_dist_r;
  logic [CLS_W-1:0]  out_cls_r;
  logic              out_last_r;

  // ---------------- pipeline advance ----------------
  assign is_classify = d_valid_r && (d_op_r == OP_CLASSIFY);
  assign load_ok     = !out_valid_r || !out_stall;
  assign n_held      = (fill_r < cfg.k) ? fill_r : cfg.k;
  assign seq_idx     = seq_r[KI_W-1:0];
  assign emit_entry  = is_classify && load_ok && (seq_r < n_held);
  assign emit_final  = is_classify && load_ok && !(seq_r < n_held);
  assign d_done      = is_classify ? emit_final : 1'b1;
  assign adv         = !d_valid_r || d_done;
  assign q_pop       = adv;

  // ---------------- stage A: memory access ----------------
  assign q_addr = QA_W'(q_item.idx);

  always_ff @(posedge clk) begin
    if (adv && q_valid) begin
      if (q_item.op == OP_QUERY && q_item.idx_ok) begin
        qmem[q_addr] <= q_item.value;
      end
      q_rd_r <= qmem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_item_r <= q_item;
    end
  end

  // ---------------- stage B: term ----------------
  always_comb begin
    diff = (b_item_r.value >= q_rd_r) ? b_item_r.value - q_rd_r : q_rd_r - b_item_r.value;
    sq   = SQ_W'(diff) * SQ_W'(diff);
    if (!b_item_r.idx_ok) begin
      term = '0;
    end else if (cfg.metric) begin
      term = SQ_W'(diff);
    end else begin
      term = sq;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_op_r   <= b_item_r.op;
      c_term_r <= term;
      c_last_r <= b_item_r.last;
      c_cls_r  <= b_item_r.cls;
    end
  end

  // ---------------- stage C: accumulate ----------------
  always_comb begin
    sum_ext     = {1'b0, sum_r} + (DIST_W + 1)'(c_term_r);
    sum_sat     = sum_ext[DIST_W] ? DIST_MAX : sum_ext[DIST_W-1:0];
    sum_nxt     = sum_r;
    d_valid_nxt = 1'b0;
    if (c_valid_r) begin
      case (c_op_r)
        OP_TRAIN: begin
          if (c_last_r) begin
            sum_nxt     = '0;
            d_valid_nxt = 1'b1;
          end else begin
            sum_nxt = sum_sat;
          end
        end
        OP_CLEAR: begin
          sum_nxt     = '0;
          d_valid_nxt = 1'b1;
        end
        OP_CLASSIFY: d_valid_nxt = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_op_r   <= c_op_r;
      d_dist_r <= sum_sat;
      d_cls_r  <= c_cls_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      sum_r     <= '0;
    end else if (adv) begin
      b_valid_r <= q_valid;
      c_valid_r <= b_valid_r;
      d_valid_r <= d_valid_nxt;
      sum_r     <= sum_nxt;
    end
  end

  // ---------------- stage D: sorted insert ----------------
  // Entries at or below the new distance stay; the rest shift down one place.
  always_comb begin
    for (int j = 0; j < K_MAX; j++) begin
      keep[j] = (KC_W'(j) < n_held) && (best_d_r[j] <= d_dist_r);
    end
    new_d[0] = keep[0] ? best_d_r[0] : d_dist_r;
    new_c[0] = keep[0] ? best_c_r[0] : d_cls_r;
    for (int j = 1; j < K_MAX; j++) begin
      if (keep[j]) begin
        new_d[j] = best_d_r[j];
        new_c[j] = best_c_r[j];
      end else if (keep[j-1]) begin
        new_d[j] = d_dist_r;
        new_c[j] = d_cls_r;
      end else begin
        new_d[j] = best_d_r[j-1];
        new_c[j] = best_c_r[j-1];
      end
    end
    fill_ins = (n_held < cfg.k) ? n_held + 1'b1 : cfg.k;
    fill_nxt = fill_r;
    if (d_valid_r) begin
      case (d_op_r)
        OP_TRAIN: fill_nxt = fill_ins;
        OP_CLEAR: fill_nxt = '0;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (d_valid_r && d_op_r == OP_TRAIN) begin
      for (int j = 0; j < K_MAX; j++) begin
        best_d_r[j] <= new_d[j];
        best_c_r[j] <= new_c[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // ---------------- vote sequencer ----------------
  // Keep the running winner; a tie goes to the lower class.
  assign vote_cls = best_c_r[seq_idx];
  assign vote_inc = votes_r[CI_W'(vote_cls)] + 1'b1;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < CLASSES; c++) begin
        votes_r[c] <= '0;
      end
      win_cls_r <= '0;
      win_cnt_r <= '0;
    end else if (emit_entry) begin
      votes_r[CI_W'(vote_cls)] <= vote_inc;
      if (vote_inc > win_cnt_r || (vote_inc == win_cnt_r && vote_cls < win_cls_r)) begin
        win_cls_r <= vote_cls;
        win_cnt_r <= vote_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
    end else if (adv) begin
      seq_r <= '0;
    end else if (emit_entry) begin
      seq_r <= seq_r + 1'b1;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_entry || emit_final) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_entry) begin
      out_kind_r <= KIND_NEIGHBOR;
      out_rank_r <= RANK_W'(seq_r);
      out_dist_r <= best_d_r[seq_idx];
      out_cls_r  <= vote_cls;
      out_last_r <= 1'b0;
    end else if (emit_final) begin
      out_kind_r <= KIND_CLASS;
      out_rank_r <= '0;
      out_dist_r <= '0;
      out_cls_r  <= win_cls_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_rank        = out_rank_r;
  assign out_distance    = out_dist_r;
  assign out_class_label = out_cls_r;
  assign out_last        = out_last_r;

  assign stat.list_fill     = fill_r;
  assign stat.classify_busy = is_classify;

endmodule

FILE: hdl/knn_nearest_class_vote.sv
// Nearest-neighbor classifier top level: config registers, front queue and back end.
// A classify transaction passes the front queue, the stage A, B and C registers and the list
// stage D into the result register, then gives one result per cycle while out_stall is low.
// Throughput: one transaction per cycle; a classify holds the list stage while it emits
// one result per held neighbor and then the predicted class, and while out_stall is high.
// Reset (rst_n low, synchronous): queue, pipeline, list and accumulator empty; k=1, squared metric.
module knn_nearest_class_vote (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [knn_pkg::CMD_W-1:0]      in_cmd,
  input  logic [knn_pkg::IDX_W-1:0]      in_feature_index,
  input  logic [knn_pkg::VAL_W-1:0]      in_feature_value,
  input  logic [knn_pkg::CLS_W-1:0]      in_sample_class,
  input  logic                           in_last_feature,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_result_kind,
  output logic [knn_pkg::RANK_W-1:0]     out_rank,
  output logic [knn_pkg::DIST_W-1:0]     out_distance,
  output logic [knn_pkg::CLS_W-1:0]      out_class_label,
  output logic                           out_last,
  input  logic                           cfg_wr_en,
  input  logic [knn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [knn_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import knn_pkg::*;

  logic [CFG_DATA_W-1:0] neighbor_count_r;
  logic                  metric_select_r;
  cfg_t                  cfg_s;
  stat_t                 stat_s;
  logic                  q_valid, q_pop;
  item_t                 q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neighbor_count_r <= CFG_DATA_W'(1);
      metric_select_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NEIGHBOR_COUNT: neighbor_count_r <= cfg_wdata;
        REG_METRIC_SELECT:  metric_select_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clamp k into 1..K_MAX
  always_comb begin
    if (neighbor_count_r == '0) begin
      cfg_s.k = KC_W'(1);
    end else if (32'(neighbor_count_r) > K_MAX) begin
      cfg_s.k = KC_W'(K_MAX);
    end else begin
      cfg_s.k = KC_W'(neighbor_count_r);
    end
    cfg_s.metric = metric_select_r;
  end

  knn_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_feature_index (in_feature_index),
    .in_feature_value (in_feature_value),
    .in_sample_class  (in_sample_class),
    .in_last_feature  (in_last_feature),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  knn_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .cfg             (cfg_s),
    .stat            (stat_s),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_rank        (out_rank),
    .out_distance    (out_distance),
    .out_class_label (out_class_label),
    .out_last        (out_last)
  );

  a_neighbor_rank : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_NEIGHBOR |->
      !out_last && (32'(out_rank) < 32'(cfg_s.k)))
    else $error("neighbor result rank beyond k or marked last");

  a_class_fields : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_CLASS |->
      out_last && out_rank == '0 && out_distance == '0)
    else $error("predicted-class result has wrong fields");

  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    32'(stat_s.list_fill) <= K_MAX)
    else $error("neighbor list fill exceeds K_MAX");

  a_busy_emits : assert property (@(posedge clk) disable iff (!rst_n)
    stat_s.classify_busy && !out_valid |=> out_valid)
    else $error("classify run left result register empty");

  a_run_order : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_valid && (out_result_kind == KIND_CLASS ||
                    32'(out_rank) == 32'($past(out_rank)) + 1))
    else $error("classify run broken or ranks out of order");

endmodule
